FILE: rtl/core/ftc_pkg.sv
// ============================================================================
// ftc_pkg - shared types and constants of the filmic tone curve
// Register map codes, fixed register widths and reset values, sample kinds.
// ============================================================================
`default_nettype none

package ftc_pkg;

  // Register widths, fixed by the register map
  localparam int EXP_W = 16;
  localparam int CON_W = 14;
  localparam int STR_W = 9;
  localparam int BLK_W = 14;
  localparam int WHT_W = 17;

  // Reset values
  localparam logic [EXP_W-1:0] EXP_RST = 16'd4096;
  localparam logic [CON_W-1:0] CON_RST = 14'd4096;
  localparam logic [STR_W-1:0] TOE_RST = 9'd128;
  localparam logic [STR_W-1:0] SHD_RST = 9'd128;
  localparam logic [BLK_W-1:0] BLK_RST = 14'd0;
  localparam logic [WHT_W-1:0] WHT_RST = 17'd65536;

  // Register index, taken from paddr[4:2]
  typedef enum logic [2:0] {
    REG_EXPOSURE = 3'd0,
    REG_CONTRAST = 3'd1,
    REG_TOE      = 3'd2,
    REG_SHOULDER = 3'd3,
    REG_BLACK    = 3'd4,
    REG_WHITE    = 3'd5
  } reg_idx_t;

  // What kind of sample travels down the pipeline
  typedef enum logic [1:0] {
    KIND_MID  = 2'd0,
    KIND_ZERO = 2'd1,
    KIND_ONE  = 2'd2
  } kind_t;

endpackage

`default_nettype wire

FILE: rtl/core/ftc_knee.sv
// ============================================================================
// ftc_knee - knee width from a strength register
// Computes round(0.3 * strength / 256) in sample format over two stages:
// a reciprocal multiply by 1/2560, then one compare-and-subtract correction.
// ============================================================================
`default_nettype none

module ftc_knee
  import ftc_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic [STR_W-1:0]     strength,
  output logic      [FRAC_BITS-1:0] knee
);

  localparam int    NW    = FRAC_BITS + 12;
  localparam int    MW    = NW - 11;
  localparam int    PW    = NW + MW;
  localparam longint MUL_L = (longint'(1) << NW) / 2560;

  localparam logic [NW-1:0] DIV_K   = NW'(2560);
  localparam logic [NW-1:0] ROUND_K = NW'(1280);
  localparam logic [PW-1:0] MUL_K   = PW'(MUL_L);

  logic [NW-1:0] n_nxt;
  logic [NW-1:0] n_r;
  logic [PW-1:0] prod_r;
  logic [MW-1:0] q0;
  logic [NW-1:0] rem0;
  logic [MW-1:0] q1;
  logic [FRAC_BITS-1:0] knee_r;

  // Numerator s*3*ONE + 1280
  assign n_nxt = ((NW'(strength) * NW'(3)) << FRAC_BITS) + ROUND_K;

  // Stage one: reciprocal multiply
  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    prod_r <= PW'(n_nxt) * MUL_K;
  end

  // Estimate is low by at most one: correct once
  assign q0   = prod_r[PW-1:NW];
  assign rem0 = n_r - NW'(q0) * DIV_K;
  assign q1   = (rem0 >= DIV_K) ? q0 + MW'(1) : q0;

  // Stage two: hold the corrected quotient
  always_ff @(posedge clk) begin
    knee_r <= q1[FRAC_BITS-1:0];
  end

  assign knee = knee_r;

endmodule

`default_nettype wire

FILE: rtl/core/ftc_div.sv
// ============================================================================
// ftc_div - pipelined restoring fraction divider
// Produces floor(rem * 2^DW / divisor) for rem < divisor, one quotient bit per
// stage, and carries a side payload along with each transaction.
// ============================================================================
`default_nettype none

module ftc_div #(
  parameter int DW = 16,
  parameter int PW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [DW-1:0] in_rem,
  input  wire logic [DW-1:0] divisor,
  input  wire logic [PW-1:0] in_pay,
  output logic               out_valid,
  output logic      [DW-1:0] out_quo,
  output logic      [PW-1:0] out_pay
);

  logic          v_r   [DW];
  logic [DW-1:0] rem_r [DW];
  logic [DW-1:0] quo_r [DW];
  logic [PW-1:0] pay_r [DW];

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic          v_src;
    logic [DW-1:0] rem_src;
    logic [DW-1:0] quo_src;
    logic [PW-1:0] pay_src;
    logic [DW:0]   rem_dbl;
    logic          ge;

    // Select the stage input: ports for the first, previous stage otherwise
    if (k == 0) begin : g_first
      assign v_src   = in_valid;
      assign rem_src = in_rem;
      assign quo_src = '0;
      assign pay_src = in_pay;
    end else begin : g_next
      assign v_src   = v_r[k-1];
      assign rem_src = rem_r[k-1];
      assign quo_src = quo_r[k-1];
      assign pay_src = pay_r[k-1];
    end

    // Shift in one bit and try the subtract
    assign rem_dbl = {rem_src, 1'b0};
    assign ge      = rem_dbl >= {1'b0, divisor};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? DW'(rem_dbl - {1'b0, divisor}) : rem_dbl[DW-1:0];
        quo_r[k] <= {quo_src[DW-2:0], ge};
        pay_r[k] <= pay_src;
      end
    end
  end

  assign out_valid = v_r[DW-1];
  assign out_quo   = quo_r[DW-1];
  assign out_pay   = pay_r[DW-1];

endmodule

`default_nettype wire

FILE: rtl/core/filmic_tone_curve.sv
// ============================================================================
// filmic_tone_curve - film-like tone curve on a stream of samples
// Exposure gain, smoothstep toe, contrast around 0.5, quadratic shoulder and
// black-to-white mapping with a final clamp, as a deep pipeline.
// ============================================================================
// Usage:
//   in_*  : stream of linear samples, in_tdata[F:0] (F = SAMPLE_FRAC_BITS).
//   out_* : stream of tone-mapped samples, out_tdata[F:0], clamped to 0..1.0.
//   cfg_* : APB register port, six registers at byte addresses 0, 4, ... 20.
//           Write registers only while no transaction is in flight.
// Throughput: one sample per clock, unless the output stalls (see Stall).
// Dividers: each of the two spends F stages, one quotient bit per stage.
// Knee widths follow a strength write via the ftc_knee registers.
// Reset clears every valid bit and loads the register reset values; in_tready
//   stays low while rst_n is low.
// Stall: while the output register waits on out_tready the pipeline still
//   advances as long as its last stage is empty; once that stage is full the
//   whole pipeline holds and in_tready drops until the result is taken.
// ============================================================================
`default_nettype none

module filmic_tone_curve
  import ftc_pkg::*;
#(
  parameter int SAMPLE_FRAC_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  // in_tdata: [F:0] sample_in, rest zero padding
  input  wire logic                                    in_tvalid,
  output logic                                         in_tready,
  input  wire logic [((SAMPLE_FRAC_BITS+8)/8)*8-1:0]   in_tdata,
  // out_tdata: [F:0] sample_out, rest zero padding
  output logic                                         out_tvalid,
  input  wire logic                                    out_tready,
  output logic      [((SAMPLE_FRAC_BITS+8)/8)*8-1:0]   out_tdata,
  // Configuration
  input  wire logic                                    cfg_psel,
  input  wire logic                                    cfg_penable,
  input  wire logic                                    cfg_pwrite,
  input  wire logic [4:0]                              cfg_paddr,
  input  wire logic [31:0]                             cfg_pwdata,
  output logic      [31:0]                             cfg_prdata,
  output logic                                         cfg_pready
);

  localparam int     F     = SAMPLE_FRAC_BITS;
  localparam int     SW    = F + 1;
  localparam int     DBW   = ((F + 8) / 8) * 8;
  localparam int     AW    = F + 4;
  localparam int     PXW   = F + 16;
  localparam int     D6W   = F + 20;
  localparam int     CW    = F + 8;
  localparam int     SPW   = 18;
  localparam int     YW    = CW + SPW;
  localparam longint ONE_L = longint'(1) << F;
  localparam longint HLF_L = ONE_L >> 1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [EXP_W-1:0] exp_r;
  logic [CON_W-1:0] con_r;
  logic [STR_W-1:0] toe_r;
  logic [STR_W-1:0] shd_r;
  logic [BLK_W-1:0] blk_r;
  logic [WHT_W-1:0] wht_r;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[4:2]);
  assign cfg_pready = 1'b1;

  // Write on the access cycle; other indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r <= EXP_RST;
      con_r <= CON_RST;
      toe_r <= TOE_RST;
      shd_r <= SHD_RST;
      blk_r <= BLK_RST;
      wht_r <= WHT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_EXPOSURE: exp_r <= cfg_pwdata[EXP_W-1:0];
        REG_CONTRAST: con_r <= cfg_pwdata[CON_W-1:0];
        REG_TOE:      toe_r <= cfg_pwdata[STR_W-1:0];
        REG_SHOULDER: shd_r <= cfg_pwdata[STR_W-1:0];
        REG_BLACK:    blk_r <= cfg_pwdata[BLK_W-1:0];
        REG_WHITE:    wht_r <= cfg_pwdata[WHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (cfg_idx)
      REG_EXPOSURE: cfg_prdata = 32'(exp_r);
      REG_CONTRAST: cfg_prdata = 32'(con_r);
      REG_TOE:      cfg_prdata = 32'(toe_r);
      REG_SHOULDER: cfg_prdata = 32'(shd_r);
      REG_BLACK:    cfg_prdata = 32'(blk_r);
      REG_WHITE:    cfg_prdata = 32'(wht_r);
      default:      cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Values derived from configuration
  // --------------------------------------------------------------------------
  logic [F-1:0]           tp_w;
  logic [F-1:0]           sk_w;
  logic [F:0]             st_w;
  logic signed [SPW-1:0]  span_r;

  ftc_knee #(.FRAC_BITS(F)) u_toe_knee (
    .clk      (clk),
    .strength (toe_r),
    .knee     (tp_w)
  );

  ftc_knee #(.FRAC_BITS(F)) u_shd_knee (
    .clk      (clk),
    .strength (shd_r),
    .knee     (sk_w)
  );

  assign st_w = SW'(ONE_L) - SW'(sk_w);

  always_ff @(posedge clk) begin
    span_r <= $signed(SPW'(wht_r)) - $signed(SPW'(blk_r));
  end

  // --------------------------------------------------------------------------
  // Pipeline control
  // --------------------------------------------------------------------------
  logic en;
  logic out_load;
  logic out_valid_r;
  logic [SW-1:0] out_data_r;
  logic s10_v_r;

  assign out_load  = !out_valid_r || out_tready;
  assign en        = !s10_v_r || out_load;
  assign in_tready = en && rst_n;

  // --------------------------------------------------------------------------
  // Stage 1: classify, exposure multiply
  // --------------------------------------------------------------------------
  logic [SW-1:0]  x_w;
  kind_t          kind_nxt;
  logic           s1_v_r;
  kind_t          s1_kind_r;
  logic [PXW-1:0] s1_prod_r;

  assign x_w = in_tdata[SW-1:0];

  always_comb begin
    if (x_w == '0) begin
      kind_nxt = KIND_ZERO;
    end else if (x_w[F]) begin
      kind_nxt = KIND_ONE;
    end else begin
      kind_nxt = KIND_MID;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: round exposure, toe select
  // --------------------------------------------------------------------------
  logic [PXW-1:0] a_sum;
  logic [AW-1:0]  a_w;
  logic           toe_on_w;
  logic           s2_v_r;
  kind_t          s2_kind_r;
  logic [AW-1:0]  s2_a_r;
  logic           s2_on_r;
  logic [F-1:0]   s2_rem_r;

  assign a_sum    = s1_prod_r + PXW'(2048);
  assign a_w      = a_sum[PXW-1:12];
  assign toe_on_w = (tp_w != '0) && (a_w < AW'(tp_w));

  // --------------------------------------------------------------------------
  // Toe divider: t = a * ONE / tp
  // --------------------------------------------------------------------------
  localparam int TPW = AW + 3;
  logic           td_v;
  logic [F-1:0]   td_q;
  logic [TPW-1:0] td_pay;

  ftc_div #(.DW(F), .PW(TPW)) u_toe_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s2_v_r),
    .in_rem    (s2_rem_r),
    .divisor   (tp_w),
    .in_pay    ({s2_kind_r, s2_on_r, s2_a_r}),
    .out_valid (td_v),
    .out_quo   (td_q),
    .out_pay   (td_pay)
  );

  // --------------------------------------------------------------------------
  // Stages 3 to 5: smoothstep tp * t^2 * (3 - 2t)
  // --------------------------------------------------------------------------
  logic           s3_v_r;
  kind_t          s3_kind_r;
  logic [AW-1:0]  s3_a_r;
  logic           s3_on_r;
  logic [2*F-1:0] s3_tt_r;
  logic [F+1:0]   s3_poly_r;

  logic           s4_v_r;
  kind_t          s4_kind_r;
  logic [AW-1:0]  s4_a_r;
  logic           s4_on_r;
  logic [2*F-1:0] s4_vp_r;
  logic [F+1:0]   s4_poly_r;

  logic           s5_v_r;
  kind_t          s5_kind_r;
  logic [AW-1:0]  s5_a_r;
  logic           s5_on_r;
  logic [2*F+1:0] s5_tp_r;

  // --------------------------------------------------------------------------
  // Stage 6: contrast multiply
  // --------------------------------------------------------------------------
  logic [AW-1:0]         toe_w;
  logic signed [AW:0]    d6_w;
  logic                  s6_v_r;
  kind_t                 s6_kind_r;
  logic signed [D6W-1:0] s6_cp_r;

  assign toe_w = s5_on_r ? AW'(s5_tp_r[2*F+1:F]) : s5_a_r;
  assign d6_w  = $signed({1'b0, toe_w}) - $signed((AW+1)'(HLF_L));

  // --------------------------------------------------------------------------
  // Stage 7: contrast round, shoulder select
  // --------------------------------------------------------------------------
  logic signed [D6W-1:0] cr7_w;
  logic signed [D6W-1:0] cs7_w;
  logic signed [CW-1:0]  c7_w;
  logic signed [CW-1:0]  st_s;
  logic signed [CW-1:0]  sk_s;
  logic signed [CW-1:0]  diff7_w;
  logic                  on7_w;
  logic                  sat7_w;
  logic                  s7_v_r;
  kind_t                 s7_kind_r;
  logic signed [CW-1:0]  s7_c_r;
  logic                  s7_on_r;
  logic                  s7_sat_r;
  logic [F-1:0]          s7_rem_r;

  assign cr7_w   = s6_cp_r + D6W'(2048);
  assign cs7_w   = cr7_w >>> 12;
  assign c7_w    = CW'(cs7_w) + $signed(CW'(HLF_L));
  assign st_s    = $signed(CW'(st_w));
  assign sk_s    = $signed(CW'(sk_w));
  assign on7_w   = (sk_w != '0) && (c7_w > st_s);
  assign diff7_w = c7_w - st_s;
  assign sat7_w  = diff7_w >= sk_s;

  // --------------------------------------------------------------------------
  // Shoulder divider: t = (c - st) * ONE / r
  // --------------------------------------------------------------------------
  localparam int SPL = CW + 4;
  logic           sd_v;
  logic [F-1:0]   sd_q;
  logic [SPL-1:0] sd_pay;

  ftc_div #(.DW(F), .PW(SPL)) u_shd_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s7_v_r),
    .in_rem    (s7_rem_r),
    .divisor   (sk_w),
    .in_pay    ({s7_kind_r, s7_sat_r, s7_on_r, s7_c_r}),
    .out_valid (sd_v),
    .out_quo   (sd_q),
    .out_pay   (sd_pay)
  );

  // --------------------------------------------------------------------------
  // Stages 8 to 10: quadratic shoulder, level map multiply
  // --------------------------------------------------------------------------
  logic [F:0]            t8_w;
  logic [F+1:0]          tm8_w;
  logic                  s8_v_r;
  kind_t                 s8_kind_r;
  logic signed [CW-1:0]  s8_c_r;
  logic                  s8_on_r;
  logic [2*F+2:0]        s8_cm_r;

  logic                  s9_v_r;
  kind_t                 s9_kind_r;
  logic signed [CW-1:0]  s9_c_r;
  logic                  s9_on_r;
  logic [2*F:0]          s9_rc_r;

  logic signed [CW-1:0]  sh_w;
  kind_t                 s10_kind_r;
  logic signed [YW-1:0]  s10_yp_r;

  // Saturate t at one
  assign t8_w  = sd_pay[CW+1] ? SW'(ONE_L) : {1'b0, sd_q};
  assign tm8_w = (F+2)'(2 * ONE_L) - (F+2)'(t8_w);
  assign sh_w  = s9_on_r ? (st_s + $signed(CW'(s9_rc_r[2*F-1:F]))) : s9_c_r;

  // --------------------------------------------------------------------------
  // Valid bits
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      s5_v_r  <= 1'b0;
      s6_v_r  <= 1'b0;
      s7_v_r  <= 1'b0;
      s8_v_r  <= 1'b0;
      s9_v_r  <= 1'b0;
      s10_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r  <= in_tvalid;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= td_v;
      s4_v_r  <= s3_v_r;
      s5_v_r  <= s4_v_r;
      s6_v_r  <= s5_v_r;
      s7_v_r  <= s6_v_r;
      s8_v_r  <= sd_v;
      s9_v_r  <= s8_v_r;
      s10_v_r <= s9_v_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage payloads
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (en) begin
      // exposure
      s1_kind_r  <= kind_nxt;
      s1_prod_r  <= PXW'(x_w[F-1:0]) * PXW'(exp_r);
      // toe select
      s2_kind_r  <= s1_kind_r;
      s2_a_r     <= a_w;
      s2_on_r    <= toe_on_w;
      s2_rem_r   <= toe_on_w ? a_w[F-1:0] : '0;
      // t^2 and 3 - 2t
      s3_kind_r  <= kind_t'(td_pay[AW+2:AW+1]);
      s3_on_r    <= td_pay[AW];
      s3_a_r     <= td_pay[AW-1:0];
      s3_tt_r    <= (2*F)'(td_q) * (2*F)'(td_q);
      s3_poly_r  <= (F+2)'(3 * ONE_L) - (F+2)'({td_q, 1'b0});
      // tp * t^2
      s4_kind_r  <= s3_kind_r;
      s4_on_r    <= s3_on_r;
      s4_a_r     <= s3_a_r;
      s4_vp_r    <= (2*F)'(tp_w) * (2*F)'(s3_tt_r[2*F-1:F]);
      s4_poly_r  <= s3_poly_r;
      // times (3 - 2t)
      s5_kind_r  <= s4_kind_r;
      s5_on_r    <= s4_on_r;
      s5_a_r     <= s4_a_r;
      s5_tp_r    <= (2*F+2)'(s4_vp_r[2*F-1:F]) * (2*F+2)'(s4_poly_r);
      // contrast
      s6_kind_r  <= s5_kind_r;
      s6_cp_r    <= D6W'(d6_w) * D6W'($signed({1'b0, con_r}));
      // shoulder select
      s7_kind_r  <= s6_kind_r;
      s7_c_r     <= c7_w;
      s7_on_r    <= on7_w;
      s7_sat_r   <= sat7_w;
      s7_rem_r   <= (on7_w && !sat7_w) ? diff7_w[F-1:0] : '0;
      // t * (2 - t)
      s8_kind_r  <= kind_t'(sd_pay[CW+3:CW+2]);
      s8_on_r    <= sd_pay[CW];
      s8_c_r     <= $signed(sd_pay[CW-1:0]);
      s8_cm_r    <= (2*F+3)'(t8_w) * (2*F+3)'(tm8_w);
      // r * comp
      s9_kind_r  <= s8_kind_r;
      s9_on_r    <= s8_on_r;
      s9_c_r     <= s8_c_r;
      s9_rc_r    <= (2*F+1)'(sk_w) * (2*F+1)'(s8_cm_r[2*F:F]);
      // level map
      s10_kind_r <= s9_kind_r;
      s10_yp_r   <= YW'(sh_w) * YW'(span_r);
    end
  end

  // --------------------------------------------------------------------------
  // Output: round, offset, clamp, register
  // --------------------------------------------------------------------------
  function automatic logic [SW-1:0] clamp_unit(input logic signed [YW-1:0] v);
    logic [SW-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > $signed(YW'(ONE_L))) begin
      res = SW'(ONE_L);
    end else begin
      res = v[SW-1:0];
    end
    return res;
  endfunction

  logic signed [YW-1:0] yr_w;
  logic signed [YW-1:0] ys_w;
  logic signed [YW-1:0] yv_w;
  logic [SW-1:0]        y_nxt;

  assign yr_w = s10_yp_r + $signed(YW'(HLF_L));
  assign ys_w = yr_w >>> F;
  assign yv_w = ys_w + $signed(YW'(blk_r));

  always_comb begin
    case (s10_kind_r)
      KIND_ZERO: y_nxt = clamp_unit($signed(YW'(blk_r)));
      KIND_ONE:  y_nxt = clamp_unit($signed(YW'(wht_r)));
      default:   y_nxt = clamp_unit(yv_w);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s10_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= y_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = DBW'(out_data_r);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Smoothstep never climbs to one: it stays below the toe knee
  a_toe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (s5_v_r && s5_on_r) |-> (s5_tp_r[2*F+1:F] < (F+2)'(ONE_L)))
    else $error("toe value reached one");

  // Shoulder output never passes one
  a_shd_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (s9_v_r && s9_on_r) |-> (sh_w <= $signed(CW'(ONE_L))))
    else $error("shoulder value above one");

  // Reset empties the output register
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("output valid after reset");

endmodule

`default_nettype wire

FILE: tb/sv/ftc_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// ftc_checker - tone curve scoreboard
// Watches the input, result and register channels, predicts each tone-mapped
// sample from its own copy of the registers and compares in order.
// ============================================================================

module ftc_checker
  import ftc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [23:0] in_tdata,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [23:0] out_tdata,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output int               fail_count,
  output int               pending
);

  localparam longint ONE  = 65536;
  localparam longint HALF = 32768;

  logic [EXP_W-1:0] m_exp;
  logic [CON_W-1:0] m_con;
  logic [STR_W-1:0] m_toe;
  logic [STR_W-1:0] m_shd;
  logic [BLK_W-1:0] m_blk;
  logic [WHT_W-1:0] m_wht;

  logic [16:0] tone_q[$];

  function automatic longint floor_div_pow2(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint knee(longint s);
    return (s * 3 * ONE + 1280) / 2560;
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v < 0) return 0;
    if (v > ONE) return ONE;
    return v;
  endfunction

  function automatic logic [16:0] tone_map(logic [16:0] x);
    longint a, v, tp, t, t2, r, st, span, y;
    if (x == 0) return 17'(clamp_unit(longint'(m_blk)));
    if (x >= ONE) return 17'(clamp_unit(longint'(m_wht)));
    a = (longint'(x) * longint'(m_exp) + 2048) >>> 12;
    // toe
    tp = knee(m_toe);
    v = a;
    if (tp > 0 && a < tp) begin
      t = (a << 16) / tp;
      t2 = (t * t) >>> 16;
      v = (((tp * t2) >>> 16) * (3 * ONE - 2 * t)) >>> 16;
    end
    // contrast
    v = HALF + floor_div_pow2((v - HALF) * longint'(m_con) + 2048, 12);
    // shoulder
    r = knee(m_shd);
    st = ONE - r;
    if (r > 0 && v > st) begin
      t = ((v - st) << 16) / r;
      if (t > ONE) t = ONE;
      t = (t * (2 * ONE - t)) >>> 16;
      v = st + ((r * t) >>> 16);
    end
    span = longint'(m_wht) - longint'(m_blk);
    y = longint'(m_blk) + floor_div_pow2(v * span + HALF, 16);
    return 17'(clamp_unit(y));
  endfunction

  assign pending = tone_q.size();

  // track registers, queue predictions, compare results
  always @(posedge clk) begin
    logic [16:0] want;
    if (!rst_n) begin
      m_exp <= EXP_RST; m_con <= CON_RST; m_toe <= TOE_RST;
      m_shd <= SHD_RST; m_blk <= BLK_RST; m_wht <= WHT_RST;
      fail_count <= 0;
      tone_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        case (reg_idx_t'(cfg_paddr[4:2]))
          REG_EXPOSURE: m_exp <= cfg_pwdata[EXP_W-1:0];
          REG_CONTRAST: m_con <= cfg_pwdata[CON_W-1:0];
          REG_TOE:      m_toe <= cfg_pwdata[STR_W-1:0];
          REG_SHOULDER: m_shd <= cfg_pwdata[STR_W-1:0];
          REG_BLACK:    m_blk <= cfg_pwdata[BLK_W-1:0];
          REG_WHITE:    m_wht <= cfg_pwdata[WHT_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) tone_q.push_back(tone_map(in_tdata[16:0]));
      if (out_tvalid && out_tready) begin
        if (tone_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %0d", out_tdata[16:0]);
          fail_count <= fail_count + 1;
        end else begin
          want = tone_q.pop_front();
          if (out_tdata[16:0] !== want) begin
            if (fail_count < 10)
              $display("mismatch: expected %0d actual %0d", want, out_tdata[16:0]);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

FILE: tb/sv/tb_filmic_tone_curve.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_filmic_tone_curve - stream test of the filmic tone curve
// Drives directed and random samples under several register settings with
// random idling on both sides; the checker predicts and compares results.
// ============================================================================

module tb_filmic_tone_curve;
  import ftc_pkg::*;

  localparam int LATENCY  = 43;
  localparam int WDOG_MAX = 5000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          fail_count;
  int          pending;
  bit          calm = 1'b0;
  int          wdog = 0;

  always #1 clk = ~clk;

  filmic_tone_curve u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  ftc_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .fail_count(fail_count), .pending(pending)
  );

  // random backpressure on the result side
  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 22);
  end

  // stop when nothing moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      wdog <= 0;
    else
      wdog <= wdog + 1;
    if (wdog >= WDOG_MAX) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // hold valid across back-to-back transactions; drop it only while idling
  task automatic send_sample(logic [16:0] s);
    while (!calm && $urandom_range(99) < 22) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, s};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic logic [16:0] rand_sample();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return 17'd0;
    if (sel == 1) return 17'(65536 + $urandom_range(65535));
    if (sel == 2) return 17'($urandom_range(4000));
    return 17'($urandom_range(65536));
  endfunction

  task automatic set_all(logic [15:0] e, logic [13:0] c, logic [8:0] t, logic [8:0] s,
                         logic [13:0] b, logic [16:0] w);
    write_reg(REG_EXPOSURE, 32'(e));
    write_reg(REG_CONTRAST, 32'(c));
    write_reg(REG_TOE, 32'(t));
    write_reg(REG_SHOULDER, 32'(s));
    write_reg(REG_BLACK, 32'(b));
    write_reg(REG_WHITE, 32'(w));
  endtask

  initial begin
    logic [16:0] directed [$];
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes and curve regions at reset settings
    directed = '{17'd0, 17'd1, 17'd2, 17'd100, 17'd5000, 17'd9830, 17'd19660,
                 17'd32768, 17'd45000, 17'd55000, 17'd60000, 17'd65535,
                 17'd65536, 17'd65537, 17'h1FFFF, 17'h15555, 17'h0AAAA};
    foreach (directed[i]) send_sample(directed[i]);
    drain();

    // extremes: full strengths, inverted levels, out of range registers
    set_all(16'd32768, 14'd8192, 9'd256, 9'd256, 14'd13107, 17'd52429);
    foreach (directed[i]) send_sample(directed[i]);
    drain();
    set_all(16'hFFFF, 14'h3FFF, 9'h1FF, 9'h1FF, 14'h3FFF, 17'd0);
    send_sample(17'd0); send_sample(17'd30000); send_sample(17'd65536);
    drain();
    set_all(16'd512, 14'd2048, 9'd0, 9'd0, 14'd0, 17'h1FFFF);
    send_sample(17'd0); send_sample(17'd30000); send_sample(17'd65536);
    drain();

    // random phases, each with fresh register values
    for (int ph = 0; ph < 8; ph++) begin
      calm = (ph == 3);
      set_all(16'($urandom_range(32768, 512)), 14'($urandom_range(8192, 2048)),
              9'($urandom_range(256)), 9'($urandom_range(256)),
              14'($urandom_range(13107)), 17'($urandom_range(65536, 52429)));
      for (int i = 0; i < 225; i++) begin
        send_sample(rand_sample());
        // pause until all results are back once
        if (ph == 5 && i == 100) begin
          in_tvalid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
      end
      drain();
    end
    calm = 1'b0;

    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/ftc_pkg.sv
rtl/core/ftc_knee.sv
rtl/core/ftc_div.sv
rtl/core/filmic_tone_curve.sv
tb/sv/ftc_checker.sv
tb/sv/tb_filmic_tone_curve.sv
